// File: src/nbc_pkg.sv
// Package: field widths, command and status codes, register indexes and reset values.
`default_nettype none
package nbc_pkg;

  localparam int POS_W     = 11;
  localparam int LEN_W     = 12;
  localparam int DRAW_W    = 16;
  localparam int REC_W     = 16;
  localparam int OUT_CNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int MAX_BITS_DEF    = 2048;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_GEN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REPEAT = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_TGT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_THR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_THR    = 2'd3;

  localparam logic [LEN_W-1:0]  CODE_LENGTH_RST = 12'd2048;
  localparam logic [REC_W-1:0]  RECORD_TGT_RST  = 16'd16384;
  localparam logic [DRAW_W-1:0] FLIP_THR_RST    = 16'd62259;
  localparam logic [DRAW_W-1:0] KEEP_THR_RST    = 16'd64225;

  localparam logic [REC_W-1:0] REC_MAX = {REC_W{1'b1}};

  typedef struct packed {
    logic [LEN_W-1:0]  code_length;
    logic [REC_W-1:0]  record_target;
    logic [DRAW_W-1:0] flip_thr;
    logic [DRAW_W-1:0] keep_thr;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/nbc_if.sv
// Channel interfaces: command items in, result items out, configuration writes.
`default_nettype none
interface nbc_in_if import nbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [POS_W-1:0]  position;
  logic              code_bit;
  logic [POS_W-1:0]  pos_first;
  logic [POS_W-1:0]  pos_second;
  logic [POS_W-1:0]  pos_third;
  logic [DRAW_W-1:0] draw;
  logic [1:0]        pick;

  modport source (output valid, command, position, code_bit, pos_first, pos_second,
                  pos_third, draw, pick, input ready);
  modport sink (input valid, command, position, code_bit, pos_first, pos_second,
                pos_third, draw, pick, output ready);
endinterface

interface nbc_out_if import nbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] zero_count;
  logic [OUT_CNT_W-1:0] one_count;
  logic [REC_W-1:0]     records_done;
  logic                 target_reached;

  modport source (output valid, status, zero_count, one_count, records_done,
                  target_reached, input ready);
  modport sink (input valid, status, zero_count, one_count, records_done,
                target_reached, output ready);
endinterface

interface nbc_cfg_if import nbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/nbc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module nbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/nbc_cfg_regs.sv
// Configuration registers written through the configuration channel.
`default_nettype none
module nbc_cfg_regs import nbc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nbc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_length   <= CODE_LENGTH_RST;
      cfg_q.record_target <= RECORD_TGT_RST;
      cfg_q.flip_thr      <= FLIP_THR_RST;
      cfg_q.keep_thr      <= KEEP_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CODE_LENGTH: cfg_q.code_length   <= cfg_ch.data[LEN_W-1:0];
        REG_RECORD_TGT:  cfg_q.record_target <= cfg_ch.data[REC_W-1:0];
        REG_FLIP_THR:    cfg_q.flip_thr      <= cfg_ch.data[DRAW_W-1:0];
        REG_KEEP_THR:    cfg_q.keep_thr      <= cfg_ch.data[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: src/nbc_seq.sv
// Sequencer: decodes items, checks positions and steps counter updates through the counter RAM.
`default_nettype none
module nbc_seq import nbc_pkg::*; #(
  parameter int  MAX_BITS    = MAX_BITS_DEF,
  parameter int  COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int AW          = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1,
  localparam int WW          = 2 * COUNT_WIDTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  nbc_in_if.sink             in_ch,
  nbc_out_if.source          out_ch,
  output logic               cnt_we_o,
  output logic [AW-1:0]      cnt_waddr_o,
  output logic [WW-1:0]      cnt_wdata_o,
  output logic [AW-1:0]      cnt_raddr_o,
  input  wire logic [WW-1:0] cnt_rdata_i,
  output logic               code_we_o,
  output logic [AW-1:0]      code_waddr_o,
  output logic               code_wdata_o,
  output logic [AW-1:0]      code_raddr_o,
  input  wire logic          code_rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [AW-1:0]          LAST_ADDR = AW'(MAX_BITS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  logic [2:0]             state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic                   bit_q, bit_d;
  logic [POS_W-1:0]       p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [DRAW_W-1:0]      draw_q, draw_d;
  logic [1:0]             pick_q, pick_d;
  logic [1:0]             idx_q, idx_d;
  logic [1:0]             status_q, status_d;
  logic [COUNT_WIDTH-1:0] zc_q, zc_d, oc_q, oc_d;
  logic [REC_W-1:0]       rec_q, rec_d;
  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic                   clr_cmd_q, clr_cmd_d;

  logic                   ov_q, ov_d;
  logic [1:0]             o_status_q, o_status_d;
  logic [OUT_CNT_W-1:0]   o_zc_q, o_zc_d, o_oc_q, o_oc_d;
  logic [REC_W-1:0]       o_rec_q, o_rec_d;
  logic                   o_tgt_q, o_tgt_d;

  logic [POS_W-1:0]       cur_pos;
  logic                   flip, new_bit;
  logic [COUNT_WIDTH-1:0] old_zero, old_one;

  function automatic logic in_range(input logic [POS_W-1:0] p, input logic [LEN_W-1:0] len);
    in_range = ({1'b0, p} < len) && (32'(p) < 32'(MAX_BITS));
  endfunction

  always_comb begin
    if (cmd_q == CMD_READ) begin
      cur_pos = pos_q;
    end else begin
      case (idx_q)
        2'd0:    cur_pos = p0_q;
        2'd1:    cur_pos = p1_q;
        default: cur_pos = p2_q;
      endcase
    end
  end

  assign cnt_raddr_o  = AW'(cur_pos);
  assign code_raddr_o = AW'(cur_pos);
  assign old_zero     = cnt_rdata_i[COUNT_WIDTH-1:0];
  assign old_one      = cnt_rdata_i[WW-1:COUNT_WIDTH];

  always_comb begin
    if (draw_q < cfg_i.flip_thr) begin
      flip = (idx_q == pick_q);
    end else if (draw_q < cfg_i.keep_thr) begin
      flip = (idx_q != pick_q);
    end else begin
      flip = 1'b1;
    end
    new_bit = code_rdata_i ^ flip;
  end

  assign in_ch.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    pos_d      = pos_q;
    bit_d      = bit_q;
    p0_d       = p0_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    draw_d     = draw_q;
    pick_d     = pick_q;
    idx_d      = idx_q;
    status_d   = status_q;
    zc_d       = zc_q;
    oc_d       = oc_q;
    rec_d      = rec_q;
    clr_addr_d = clr_addr_q;
    clr_cmd_d  = clr_cmd_q;
    ov_d       = ov_q && !out_ch.ready;
    o_status_d = o_status_q;
    o_zc_d     = o_zc_q;
    o_oc_d     = o_oc_q;
    o_rec_d    = o_rec_q;
    o_tgt_d    = o_tgt_q;

    cnt_we_o     = 1'b0;
    cnt_waddr_o  = AW'(cur_pos);
    cnt_wdata_o  = cnt_rdata_i;
    code_we_o    = 1'b0;
    code_waddr_o = AW'(pos_q);
    code_wdata_o = bit_q;

    case (state_q)
      S_CLEAR: begin
        cnt_we_o    = 1'b1;
        cnt_waddr_o = clr_addr_q;
        cnt_wdata_o = '0;
        clr_addr_d  = clr_addr_q + AW'(1);
        if (clr_addr_q == LAST_ADDR) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_d    = in_ch.command;
          pos_d    = in_ch.position;
          bit_d    = in_ch.code_bit;
          p0_d     = in_ch.pos_first;
          p1_d     = in_ch.pos_second;
          p2_d     = in_ch.pos_third;
          draw_d   = in_ch.draw;
          pick_d   = (in_ch.pick == 2'd3) ? 2'd2 : in_ch.pick;
          idx_d    = 2'd0;
          status_d = STAT_OK;
          zc_d     = '0;
          oc_d     = '0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        case (cmd_q)
          CMD_LOAD: begin
            if (in_range(pos_q, cfg_i.code_length)) begin
              code_we_o = 1'b1;
            end else begin
              status_d = STAT_RANGE;
            end
            state_d = S_DONE;
          end
          CMD_GEN: begin
            if (p0_q == p1_q || p0_q == p2_q || p1_q == p2_q) begin
              status_d = STAT_REPEAT;
              state_d  = S_DONE;
            end else if (!in_range(p0_q, cfg_i.code_length) ||
                         !in_range(p1_q, cfg_i.code_length) ||
                         !in_range(p2_q, cfg_i.code_length)) begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end
          CMD_READ: begin
            if (in_range(pos_q, cfg_i.code_length)) begin
              state_d = S_RD;
            end else begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end
          end
          default: begin
            rec_d      = '0;
            clr_addr_d = '0;
            clr_cmd_d  = 1'b1;
            state_d    = S_CLEAR;
          end
        endcase
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (cmd_q == CMD_READ) begin
          zc_d    = old_zero;
          oc_d    = old_one;
          state_d = S_DONE;
        end else begin
          cnt_we_o = 1'b1;
          if (new_bit) begin
            cnt_wdata_o = {(old_one == CNT_MAX) ? old_one : old_one + 1'b1, old_zero};
          end else begin
            cnt_wdata_o = {old_one, (old_zero == CNT_MAX) ? old_zero : old_zero + 1'b1};
          end
          if (idx_q == 2'd2) begin
            rec_d   = (rec_q == REC_MAX) ? rec_q : rec_q + 1'b1;
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!ov_q || out_ch.ready) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_zc_d     = OUT_CNT_W'(zc_q);
          o_oc_d     = OUT_CNT_W'(oc_q);
          o_rec_d    = rec_q;
          o_tgt_d    = (rec_q >= cfg_i.record_target);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      clr_cmd_q  <= 1'b0;
      rec_q      <= '0;
      idx_q      <= '0;
      cmd_q      <= CMD_LOAD;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      clr_cmd_q  <= clr_cmd_d;
      rec_q      <= rec_d;
      idx_q      <= idx_d;
      cmd_q      <= cmd_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    bit_q      <= bit_d;
    p0_q       <= p0_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    draw_q     <= draw_d;
    pick_q     <= pick_d;
    status_q   <= status_d;
    zc_q       <= zc_d;
    oc_q       <= oc_d;
    o_status_q <= o_status_d;
    o_zc_q     <= o_zc_d;
    o_oc_q     <= o_oc_d;
    o_rec_q    <= o_rec_d;
    o_tgt_q    <= o_tgt_d;
  end

  assign out_ch.valid          = ov_q;
  assign out_ch.status         = o_status_q;
  assign out_ch.zero_count     = o_zc_q;
  assign out_ch.one_count      = o_oc_q;
  assign out_ch.records_done   = o_rec_q;
  assign out_ch.target_reached = o_tgt_q;

endmodule
`default_nettype wire

// File: src/negative_database_bit_counter.sv
// Top level: negative-database bit counter with code store and per-position counters.
//
// Items arrive on in_ch, each with a command: load a code bit, generate a record, read
// one position's counts or clear all counters. Every item yields exactly one result item
// on out_ch with a status, the read counts, the record count and the target flag.
// Configuration registers are written on cfg_ch, which is always ready; write them only
// while the block is idle.
// A load or a rejected item finishes after the position check; a read reads one position
// from the counter RAM, a generated record makes three read-modify-write passes through
// the counter RAM, one per position, and a clear walks every counter entry. The block
// takes one item at a time and is not ready while an item is in progress.
// After reset the counter RAM is swept to zero, during which no item is accepted;
// configuration writes are taken throughout. The code store is not cleared.
// The result sits in an output register; if the receiver stalls, the block may still
// accept the next item and holds its finished result until the register frees.
`default_nettype none
module negative_database_bit_counter import nbc_pkg::*; #(
  parameter int MAX_BITS    = MAX_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nbc_in_if.sink    in_ch,
  nbc_out_if.source out_ch,
  nbc_cfg_if.sink   cfg_ch
);

  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int WW = 2 * COUNT_WIDTH;

  cfg_t          cfg;
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr, cnt_raddr;
  logic [WW-1:0] cnt_wdata, cnt_rdata;
  logic          code_we, code_wdata, code_rdata;
  logic [AW-1:0] code_waddr, code_raddr;

  nbc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  nbc_ram #(.WIDTH(WW), .DEPTH(MAX_BITS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  nbc_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (code_waddr),
    .wdata_i (code_wdata),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  nbc_seq #(.MAX_BITS(MAX_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cnt_we_o     (cnt_we),
    .cnt_waddr_o  (cnt_waddr),
    .cnt_wdata_o  (cnt_wdata),
    .cnt_raddr_o  (cnt_raddr),
    .cnt_rdata_i  (cnt_rdata),
    .code_we_o    (code_we),
    .code_waddr_o (code_waddr),
    .code_wdata_o (code_wdata),
    .code_raddr_o (code_raddr),
    .code_rdata_i (code_rdata)
  );

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench: command items against a behavioural copy of the counters, plus configuration.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nbc_pkg::*;

  localparam int          CLK_HALF       = 5;
  localparam int          RESET_CYCLES   = 12;
  localparam int          QUIET_LIMIT    = 20000;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          DEPTH          = MAX_BITS_DEF;
  localparam int          CNT_W          = COUNT_WIDTH_DEF;
  localparam int          PHASE_ITEMS    = 80;
  localparam int unsigned REPEAT_RECORDS = 40;

  typedef struct packed {
    cmd_e              command;
    logic [POS_W-1:0]  position;
    logic              code_bit;
    logic [POS_W-1:0]  pos_first;
    logic [POS_W-1:0]  pos_second;
    logic [POS_W-1:0]  pos_third;
    logic [DRAW_W-1:0] draw;
    logic [1:0]        pick;
  } command_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] zero_count;
    logic [OUT_CNT_W-1:0] one_count;
    logic [REC_W-1:0]     records_done;
    logic                 target_reached;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  nbc_in_if  in_ch ();
  nbc_out_if out_ch ();
  nbc_cfg_if cfg_ch ();

  negative_database_bit_counter u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cfg_t             shadow_cfg;
  logic             code_bits_q   [DEPTH];
  bit               code_known_q  [DEPTH];
  logic [CNT_W-1:0] zero_counts_q [DEPTH];
  logic [CNT_W-1:0] one_counts_q  [DEPTH];
  logic [REC_W-1:0] records_q;

  result_t     awaited_results [$];
  int unsigned mismatches = 0;
  bit          rx_stalls  = 1'b1;
  bit          tx_gaps    = 1'b1;

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned random_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned code_span();
    return (shadow_cfg.code_length > DEPTH) ? DEPTH : shadow_cfg.code_length;
  endfunction

  function automatic result_t step_counters(command_t c);
    result_t          r;
    logic [POS_W-1:0] spots [3];
    int unsigned      span;
    int unsigned      special;
    int unsigned      i;
    logic             flip;
    logic             value;
    r = '0;
    span = code_span();
    case (c.command)
      CMD_LOAD: begin
        if (c.position < span) begin
          code_bits_q[c.position] = c.code_bit;
          code_known_q[c.position] = 1'b1;
        end else begin
          r.status = STAT_RANGE;
        end
      end
      CMD_GEN: begin
        spots[0] = c.pos_first;
        spots[1] = c.pos_second;
        spots[2] = c.pos_third;
        special = (c.pick > 2'd2) ? 32'd2 : 32'(c.pick);
        if (spots[0] == spots[1] || spots[0] == spots[2] || spots[1] == spots[2]) begin
          r.status = STAT_REPEAT;
        end else if (spots[0] >= span || spots[1] >= span || spots[2] >= span) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = 0; i < 3; i++) begin
            if (c.draw < shadow_cfg.flip_thr) flip = (i == special);
            else if (c.draw < shadow_cfg.keep_thr) flip = (i != special);
            else flip = 1'b1;
            value = code_bits_q[spots[i]] ^ flip;
            if (value) begin
              if (one_counts_q[spots[i]] != '1)
                one_counts_q[spots[i]] = one_counts_q[spots[i]] + 1'b1;
            end else begin
              if (zero_counts_q[spots[i]] != '1)
                zero_counts_q[spots[i]] = zero_counts_q[spots[i]] + 1'b1;
            end
          end
          if (records_q != REC_MAX) records_q = records_q + 1'b1;
        end
      end
      CMD_READ: begin
        if (c.position < span) begin
          r.zero_count = zero_counts_q[c.position][OUT_CNT_W-1:0];
          r.one_count  = one_counts_q[c.position][OUT_CNT_W-1:0];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < DEPTH; i++) begin
          zero_counts_q[i] = '0;
          one_counts_q[i] = '0;
        end
        records_q = '0;
      end
      default: ;
    endcase
    r.records_done = records_q;
    r.target_reached = (records_q >= shadow_cfg.record_target);
    return r;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result item arrived with nothing awaited");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_ch.status));
        check_field("zero_count", want.zero_count, out_ch.zero_count);
        check_field("one_count", want.one_count, out_ch.one_count);
        check_field("records_done", want.records_done, out_ch.records_done);
        check_field("target_reached", 16'(want.target_reached),
                    16'(out_ch.target_reached));
      end
    end
  end

  initial begin : result_receiver
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && rx_stalls && $urandom_range(0, 3) == 0) hold = random_gap();
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic send_item(command_t c);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? random_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.command;
    in_ch.position   <= c.position;
    in_ch.code_bit   <= c.code_bit;
    in_ch.pos_first  <= c.pos_first;
    in_ch.pos_second <= c.pos_second;
    in_ch.pos_third  <= c.pos_third;
    in_ch.draw       <= c.draw;
    in_ch.pick       <= c.pick;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    awaited_results.push_back(step_counters(c));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (reg_index)
      REG_CODE_LENGTH: shadow_cfg.code_length = value[LEN_W-1:0];
      REG_RECORD_TGT:  shadow_cfg.record_target = value;
      REG_FLIP_THR:    shadow_cfg.flip_thr = value;
      REG_KEEP_THR:    shadow_cfg.keep_thr = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic command_t noise_command(cmd_e op);
    command_t c;
    c.command    = op;
    c.position   = POS_W'($urandom_range(0, DEPTH - 1));
    c.code_bit   = 1'($urandom_range(0, 1));
    c.pos_first  = POS_W'($urandom_range(0, DEPTH - 1));
    c.pos_second = POS_W'($urandom_range(0, DEPTH - 1));
    c.pos_third  = POS_W'($urandom_range(0, DEPTH - 1));
    c.draw       = DRAW_W'($urandom_range(0, 65535));
    c.pick       = 2'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic send_load(logic [POS_W-1:0] spot, logic value);
    command_t c;
    c = noise_command(CMD_LOAD);
    c.position = spot;
    c.code_bit = value;
    send_item(c);
  endtask

  task automatic send_read(logic [POS_W-1:0] spot);
    command_t c;
    c = noise_command(CMD_READ);
    c.position = spot;
    send_item(c);
  endtask

  // Any in-range position of a record gets a code bit first, so no unloaded bit is read.
  task automatic send_record(logic [POS_W-1:0] first, logic [POS_W-1:0] second,
                             logic [POS_W-1:0] third, logic [DRAW_W-1:0] draw,
                             logic [1:0] pick);
    logic [POS_W-1:0] spots [3];
    command_t         c;
    int               i;
    spots[0] = first;
    spots[1] = second;
    spots[2] = third;
    for (i = 0; i < 3; i++)
      if (spots[i] < code_span() && !code_known_q[spots[i]])
        send_load(spots[i], 1'($urandom_range(0, 1)));
    c = noise_command(CMD_GEN);
    c.pos_first  = first;
    c.pos_second = second;
    c.pos_third  = third;
    c.draw       = draw;
    c.pick       = pick;
    send_item(c);
  endtask

  function automatic logic [DRAW_W-1:0] random_draw();
    case ($urandom_range(0, 7))
      0:       return shadow_cfg.flip_thr;
      1:       return shadow_cfg.flip_thr - 1'b1;
      2:       return shadow_cfg.keep_thr;
      3:       return shadow_cfg.keep_thr - 1'b1;
      default: return DRAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_spot(int unsigned span);
    if (span != 0 && $urandom_range(0, 4) != 0) return POS_W'($urandom_range(0, span - 1));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  task automatic random_item();
    int unsigned      span;
    int unsigned      roll;
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] d;
    span = code_span();
    roll = $urandom_range(0, 99);
    if (roll < 55 && span >= 3) begin
      a = POS_W'($urandom_range(0, span - 1));
      do b = POS_W'($urandom_range(0, span - 1)); while (b == a);
      do d = POS_W'($urandom_range(0, span - 1)); while (d == a || d == b);
      send_record(a, b, d, random_draw(), 2'($urandom_range(0, 3)));
    end else if (roll < 65) begin
      a = random_spot(span);
      b = random_spot(span);
      d = POS_W'($urandom_range(0, DEPTH - 1));
      case ($urandom_range(0, 2))
        0:       b = a;
        1:       d = a;
        default: ;
      endcase
      send_record(a, b, d, random_draw(), 2'($urandom_range(0, 3)));
    end else if (roll < 80) begin
      send_load(random_spot(span), 1'($urandom_range(0, 1)));
    end else if (roll < 97) begin
      send_read(random_spot(span));
    end else begin
      send_item(noise_command(CMD_CLEAR));
    end
  endtask

  task automatic run_phase(logic [LEN_W-1:0] span, logic [REC_W-1:0] target,
                           logic [DRAW_W-1:0] flip_thr, logic [DRAW_W-1:0] keep_thr,
                           bit stalls);
    wait_idle();
    write_reg(REG_CODE_LENGTH, CFG_DAT_W'(span));
    write_reg(REG_RECORD_TGT, target);
    write_reg(REG_FLIP_THR, flip_thr);
    write_reg(REG_KEEP_THR, keep_thr);
    rx_stalls = stalls;
    tx_gaps = stalls;
    repeat (PHASE_ITEMS) begin
      random_item();
      if ($urandom_range(0, 99) == 0) wait_idle();
    end
  endtask

  task automatic test_commands_and_thresholds();
    send_load(11'd0, 1'b0);
    send_load(11'd2047, 1'b1);
    send_load(11'd1, 1'b1);
    send_load(11'd1024, 1'b0);
    send_load(11'd2, 1'b0);
    send_record(11'd0, 11'd1, 11'd2047, 16'd0, 2'd0);
    send_record(11'd0, 11'd1, 11'd2047, FLIP_THR_RST - 1'b1, 2'd1);
    send_record(11'd0, 11'd1, 11'd2047, FLIP_THR_RST, 2'd2);
    send_record(11'd0, 11'd1, 11'd2047, KEEP_THR_RST - 1'b1, 2'd3);
    send_record(11'd0, 11'd1, 11'd2047, KEEP_THR_RST, 2'd0);
    send_record(11'd1024, 11'd2, 11'd2047, 16'hFFFF, 2'd1);
    send_record(11'd0, 11'd0, 11'd1, 16'd0, 2'd0);
    send_record(11'd1, 11'd2, 11'd1, 16'd0, 2'd1);
    send_record(11'd2047, 11'd1, 11'd1, 16'd0, 2'd2);
    send_read(11'd0);
    send_read(11'd1);
    send_read(11'd2047);
    send_read(11'd1024);
    send_item(noise_command(CMD_CLEAR));
    send_read(11'd2047);
  endtask

  task automatic test_length_and_target();
    wait_idle();
    write_reg(REG_CODE_LENGTH, 16'd3);
    write_reg(REG_RECORD_TGT, 16'd0);
    send_load(11'd3, 1'b1);
    send_read(11'd3);
    send_read(11'd2);
    send_record(11'd0, 11'd1, 11'd2, 16'd100, 2'd1);
    send_record(11'd0, 11'd1, 11'd3, 16'd100, 2'd1);
    send_record(11'd3, 11'd3, 11'd1, 16'd100, 2'd0);
    send_record(11'd2047, 11'd2047, 11'd0, 16'd100, 2'd2);
    wait_idle();
    write_reg(REG_CODE_LENGTH, 16'd2);
    send_record(11'd0, 11'd1, 11'd2, 16'd100, 2'd0);
    send_load(11'd2, 1'b1);
    send_read(11'd1);
    wait_idle();
    write_reg(REG_CODE_LENGTH, 16'h0FFF);
    send_read(11'd2047);
    send_load(11'd2047, 1'b0);
    send_record(11'd2047, 11'd0, 11'd1024, 16'd7, 2'd2);
    wait_idle();
    write_reg(REG_CODE_LENGTH, CFG_DAT_W'(CODE_LENGTH_RST));
    write_reg(REG_RECORD_TGT, RECORD_TGT_RST);
  endtask

  task automatic test_random_traffic();
    run_phase(CODE_LENGTH_RST, REC_W'($urandom_range(20, 120)), FLIP_THR_RST, KEEP_THR_RST,
              1'b1);
    run_phase(12'd3, 16'd0, 16'd0, 16'd0, 1'b1);
    run_phase(LEN_W'($urandom_range(4, 64)), REC_W'($urandom_range(0, 65535)), 16'hFFFF,
              16'hFFFF, 1'b0);
    run_phase(LEN_W'($urandom_range(3, 2048)), REC_W'($urandom_range(0, 200)),
              DRAW_W'($urandom_range(0, 65535)), DRAW_W'($urandom_range(0, 65535)), 1'b1);
    run_phase(12'hFFF, 16'hFFFF, 16'd32768, 16'd49152, 1'b1);
  endtask

  // Records on one set of positions run back to back past the record target.
  task automatic test_repeated_records();
    wait_idle();
    write_reg(REG_RECORD_TGT, 16'd25);
    write_reg(REG_FLIP_THR, FLIP_THR_RST);
    write_reg(REG_KEEP_THR, KEEP_THR_RST);
    rx_stalls = 1'b0;
    tx_gaps = 1'b0;
    send_load(11'd10, 1'b0);
    send_load(11'd11, 1'b1);
    send_load(11'd12, 1'b0);
    repeat (REPEAT_RECORDS) send_record(11'd10, 11'd11, 11'd12, 16'd0, 2'd2);
    send_read(11'd10);
    send_read(11'd11);
    send_read(11'd12);
    rx_stalls = 1'b1;
    tx_gaps = 1'b1;
    send_item(noise_command(CMD_CLEAR));
    send_read(11'd11);
  endtask

  initial begin : main
    int i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.position = '0;
    in_ch.code_bit = 1'b0;
    in_ch.pos_first = '0;
    in_ch.pos_second = '0;
    in_ch.pos_third = '0;
    in_ch.draw = '0;
    in_ch.pick = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CODE_LENGTH;
    cfg_ch.data = '0;
    shadow_cfg.code_length = CODE_LENGTH_RST;
    shadow_cfg.record_target = RECORD_TGT_RST;
    shadow_cfg.flip_thr = FLIP_THR_RST;
    shadow_cfg.keep_thr = KEEP_THR_RST;
    for (i = 0; i < DEPTH; i++) begin
      code_bits_q[i] = 1'b0;
      code_known_q[i] = 1'b0;
      zero_counts_q[i] = '0;
      one_counts_q[i] = '0;
    end
    records_q = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands_and_thresholds();
    test_length_and_target();
    test_random_traffic();
    test_repeated_records();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
